// ===== rtl/pelb_pkg.sv =====
package pelb_pkg;

    // page geometry
    localparam int unsigned PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = 12;
    localparam logic [PAGE_SHIFT-1:0] PAGE_MASK = PAGE_SHIFT'(PAGE_BYTES - 1);

    // field widths
    localparam int FUNC_W  = 2;
    localparam int PA_W    = 52;
    localparam int BC_W    = 32;
    localparam int PI_W    = 32;
    localparam int ST_W    = 3;
    localparam int CNT_W   = 7;
    localparam int TOTAL_W = 32;
    localparam int PAGES_W = 32;

    // stream widths, tdata padded to whole bytes
    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 96;
    localparam int M_PAD_W   = M_TDATA_W - (ST_W + PA_W + CNT_W + TOTAL_W);

    // pages touched by one range never exceed 2^20 + 1
    localparam int LEFT_W = BC_W - PAGE_SHIFT + 1;

    // shared adder width, covers page limits up to 2^41 and byte sums
    localparam int ALU_W = 44;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 53;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PHYS_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGES_EXT = 2'd2;

    // request functions
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FN_XLATE  = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_INDEX    = 3'd1;
    localparam logic [ST_W-1:0] ST_ADDR     = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;
    localparam logic [ST_W-1:0] ST_NOCAP    = 3'd5;

    // shared add/subtract unit operands and result
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;
    } alu_rsp_t;

endpackage

// ===== rtl/page_extent_list_builder.sv =====
// Page extent list builder. Keeps a list of physical page extents (base page, page
// count) with an extent count and a total page count, driven by one request at a
// time on the s_ stream and answered by one result on the m_ stream. A clear goes
// straight to the result register. An append finds its page count and page limit,
// then places the range run by run, one extent per run, each step going through a
// single shared 44-bit add/subtract unit under the sequencer. A translate checks
// the index, then walks the extents through the single registered read port of the
// extent memory. s_tready is high only between requests; a finished result waits
// in the output register until taken, and the next result waits in its last step
// while that register is still full. The extent memory needs no clearing after
// reset. The user must write configuration registers (cfg_we/cfg_index/cfg_wdata)
// only while no request is in flight; the block itself does not enforce this.
module page_extent_list_builder #(
    parameter int MAX_EXTENTS = 64,
    parameter int ADDR_BITS   = 52
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [pelb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pelb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: phys_addr[51:0], byte_count[83:52], page_index[115:84], zero pad
    input  logic [pelb_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: func[1:0]
    input  logic [pelb_pkg::S_TUSER_W-1:0]  s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: status[2:0], out_addr[54:3], entry_count[61:55], total_pages[93:62], pad
    output logic [pelb_pkg::M_TDATA_W-1:0]  m_tdata
);
    import pelb_pkg::*;

    localparam int DEPTH  = (MAX_EXTENTS < 127) ? MAX_EXTENTS : 127;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_SH = (ADDR_BITS - PAGE_SHIFT < 41) ? ADDR_BITS - PAGE_SHIFT : 41;
    localparam int LIM_W  = CAP_SH + 1;
    localparam int BASE_W = CAP_SH;
    localparam int PN_W   = (LIM_W > PA_W - PAGE_SHIFT) ? LIM_W : PA_W - PAGE_SHIFT;
    localparam logic [ALU_W-1:0] LIM_CAP = ALU_W'(1) << CAP_SH;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef enum logic [21:0] {
        S_IDLE    = 22'(1) << 0,
        S_A_LEFT1 = 22'(1) << 1,
        S_A_LEFT2 = 22'(1) << 2,
        S_A_LIM1  = 22'(1) << 3,
        S_A_LIM2  = 22'(1) << 4,
        S_P_CHK   = 22'(1) << 5,
        S_P_EXT1  = 22'(1) << 6,
        S_P_EXT2  = 22'(1) << 7,
        S_T1      = 22'(1) << 8,
        S_T2      = 22'(1) << 9,
        S_T3      = 22'(1) << 10,
        S_T4      = 22'(1) << 11,
        S_T5      = 22'(1) << 12,
        S_U1      = 22'(1) << 13,
        S_U2      = 22'(1) << 14,
        S_U3      = 22'(1) << 15,
        S_U4      = 22'(1) << 16,
        S_X_CHK   = 22'(1) << 17,
        S_X_CMP   = 22'(1) << 18,
        S_X_ADDR  = 22'(1) << 19,
        S_DONE    = 22'(1) << 20,
        S_SPARE   = 22'(1) << 21
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CFG_DATA_W-1:0] max_pa_reg;
    logic [CNT_W-1:0]      entries_reg;
    logic [PAGES_W-1:0]    max_ppe_reg;

    // list state
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    // working registers
    logic [PN_W-1:0]       pn_reg, pn_next;
    logic [PAGE_SHIFT-1:0] ofs_reg, ofs_next;
    logic [BC_W-1:0]       bytes_reg, bytes_next;
    logic [PI_W-1:0]       index_reg, index_next;
    logic [LEFT_W-1:0]     left_reg, left_next;
    logic [LIM_W-1:0]      lim_reg, lim_next;
    logic [ALU_W-1:0]      tmp_reg, tmp_next;
    logic [LEFT_W-1:0]     take_reg, take_next;
    logic [ALU_W-1:0]      end_reg, end_next;
    logic [BASE_W-1:0]     cur_base_reg, cur_base_next;
    logic [PAGES_W-1:0]    cur_pages_reg, cur_pages_next;
    logic [CNT_W-1:0]      cur_idx_reg, cur_idx_next;
    logic [CNT_W-1:0]      e_reg, e_next;
    logic [ST_W-1:0]       st_reg, st_next;
    logic [PA_W-1:0]       oaddr_reg, oaddr_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // shared unit and memory hookup
    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;
    logic               mem_we;
    logic [CNT_W-1:0]   rd_cnt;
    logic [BASE_W-1:0]  rd_base;
    logic [PAGES_W-1:0] rd_pages;

    // derived values
    logic [CNT_W-1:0]   cap;
    logic [PAGES_W-1:0] limit_per;
    logic [TOTAL_W-1:0] headroom;
    logic               extend;

    // request fields
    logic [FUNC_W-1:0] in_func;
    logic [PA_W-1:0]   in_addr;
    logic [BC_W-1:0]   in_bytes;
    logic [PI_W-1:0]   in_index;

    assign in_func  = s_tuser[FUNC_W-1:0];
    assign in_addr  = s_tdata[PA_W-1:0];
    assign in_bytes = s_tdata[PA_W+BC_W-1:PA_W];
    assign in_index = s_tdata[PA_W+BC_W+PI_W-1:PA_W+BC_W];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign cap       = (entries_reg < DEPTH_C) ? entries_reg : DEPTH_C;
    assign limit_per = (max_ppe_reg == '0) ? PAGES_W'(1) : max_ppe_reg;
    assign headroom  = ~total_reg;

    pelb_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    pelb_mem #(
        .DEPTH  (DEPTH),
        .IDX_W  (IDX_W),
        .BASE_W (BASE_W)
    ) u_mem (
        .aclk     (aclk),
        .wr_en    (mem_we),
        .wr_idx   (cur_idx_reg[IDX_W-1:0]),
        .wr_base  (cur_base_reg),
        .wr_pages (alu_rsp.res[PAGES_W-1:0]),
        .rd_idx   (rd_cnt[IDX_W-1:0]),
        .rd_base  (rd_base),
        .rd_pages (rd_pages)
    );

    // sequencer
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        pn_next        = pn_reg;
        ofs_next       = ofs_reg;
        bytes_next     = bytes_reg;
        index_next     = index_reg;
        left_next      = left_reg;
        lim_next       = lim_reg;
        tmp_next       = tmp_reg;
        take_next      = take_reg;
        end_next       = end_reg;
        cur_base_next  = cur_base_reg;
        cur_pages_next = cur_pages_reg;
        cur_idx_next   = cur_idx_reg;
        e_next         = e_reg;
        st_next        = st_reg;
        oaddr_next     = oaddr_reg;
        m_valid_next   = m_valid_reg & ~m_tready;
        m_data_next    = m_data_reg;
        alu_req.a      = '0;
        alu_req.b      = '0;
        alu_req.sub    = 1'b0;
        mem_we         = 1'b0;
        rd_cnt         = e_reg;
        extend         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    pn_next    = PN_W'(in_addr[PA_W-1:PAGE_SHIFT]);
                    ofs_next   = in_addr[PAGE_SHIFT-1:0];
                    bytes_next = in_bytes;
                    index_next = in_index;
                    st_next    = ST_OK;
                    oaddr_next = '0;
                    e_next     = '0;
                    unique case (in_func)
                        FN_CLEAR: begin
                            count_next = '0;
                            total_next = '0;
                            state_next = S_DONE;
                        end
                        FN_APPEND: begin
                            if (cap == '0) begin
                                st_next    = ST_NOCAP;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_A_LEFT1;
                            end
                        end
                        FN_XLATE: state_next = S_X_CHK;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            // pages touched = (offset + bytes + page_mask) >> page_shift
            S_A_LEFT1: begin
                alu_req.a  = ALU_W'(bytes_reg);
                alu_req.b  = ALU_W'(PAGE_MASK);
                tmp_next   = alu_rsp.res;
                state_next = S_A_LEFT2;
            end
            S_A_LEFT2: begin
                alu_req.a  = tmp_reg;
                alu_req.b  = ALU_W'(ofs_reg);
                left_next  = alu_rsp.res[PAGE_SHIFT +: LEFT_W];
                state_next = S_A_LIM1;
            end
            // page limit from max_phys_addr rounded up
            S_A_LIM1: begin
                alu_req.a  = ALU_W'(max_pa_reg[CFG_DATA_W-1:PAGE_SHIFT]);
                alu_req.b  = ALU_W'(|max_pa_reg[PAGE_SHIFT-1:0]);
                tmp_next   = alu_rsp.res;
                state_next = S_A_LIM2;
            end
            // clamp to the address space
            S_A_LIM2: begin
                alu_req.a   = tmp_reg;
                alu_req.b   = LIM_CAP;
                alu_req.sub = 1'b1;
                lim_next    = alu_rsp.borrow ? tmp_reg[LIM_W-1:0] : LIM_CAP[LIM_W-1:0];
                state_next  = S_P_CHK;
            end
            // per-run checks: done, address, total
            S_P_CHK: begin
                rd_cnt      = count_reg - CNT_W'(1);
                alu_req.a   = ALU_W'(pn_reg);
                alu_req.b   = ALU_W'(lim_reg);
                alu_req.sub = 1'b1;
                if (left_reg == '0) begin
                    state_next = S_DONE;
                end else if (!alu_rsp.borrow) begin
                    st_next    = ST_ADDR;
                    state_next = S_DONE;
                end else if (&total_reg) begin
                    st_next    = ST_OVERFLOW;
                    state_next = S_DONE;
                end else begin
                    state_next = S_P_EXT1;
                end
            end
            // end page of the last extent
            S_P_EXT1: begin
                rd_cnt         = count_reg - CNT_W'(1);
                alu_req.a      = ALU_W'(rd_base);
                alu_req.b      = ALU_W'(rd_pages);
                end_next       = alu_rsp.res;
                cur_base_next  = rd_base;
                cur_pages_next = rd_pages;
                state_next     = S_P_EXT2;
            end
            // extend the last extent or open a new one
            S_P_EXT2: begin
                alu_req.a   = ALU_W'(cur_pages_reg);
                alu_req.b   = ALU_W'(limit_per);
                alu_req.sub = 1'b1;
                extend      = (count_reg != '0) && (ALU_W'(pn_reg) == end_reg) &&
                              alu_rsp.borrow;
                if (extend) begin
                    cur_idx_next = count_reg - CNT_W'(1);
                    state_next   = S_T1;
                end else if (count_reg >= cap) begin
                    st_next    = ST_FULL;
                    state_next = S_DONE;
                end else begin
                    cur_idx_next   = count_reg;
                    cur_base_next  = BASE_W'(pn_reg);
                    cur_pages_next = '0;
                    count_next     = count_reg + CNT_W'(1);
                    state_next     = S_T1;
                end
            end
            // take = min(left, lim - pn, total headroom, extent headroom)
            S_T1: begin
                alu_req.a   = ALU_W'(lim_reg);
                alu_req.b   = ALU_W'(pn_reg);
                alu_req.sub = 1'b1;
                tmp_next    = alu_rsp.res;
                state_next  = S_T2;
            end
            S_T2: begin
                alu_req.a   = ALU_W'(left_reg);
                alu_req.b   = tmp_reg;
                alu_req.sub = 1'b1;
                take_next   = alu_rsp.borrow ? left_reg : tmp_reg[LEFT_W-1:0];
                state_next  = S_T3;
            end
            S_T3: begin
                alu_req.a   = ALU_W'(take_reg);
                alu_req.b   = ALU_W'(headroom);
                alu_req.sub = 1'b1;
                if (!alu_rsp.borrow) begin
                    take_next = LEFT_W'(headroom);
                end
                state_next  = S_T4;
            end
            S_T4: begin
                alu_req.a   = ALU_W'(limit_per);
                alu_req.b   = ALU_W'(cur_pages_reg);
                alu_req.sub = 1'b1;
                tmp_next    = alu_rsp.res;
                state_next  = S_T5;
            end
            S_T5: begin
                alu_req.a   = ALU_W'(take_reg);
                alu_req.b   = tmp_reg;
                alu_req.sub = 1'b1;
                if (!alu_rsp.borrow) begin
                    take_next = tmp_reg[LEFT_W-1:0];
                end
                state_next  = S_U1;
            end
            // apply the run
            S_U1: begin
                alu_req.a  = ALU_W'(pn_reg);
                alu_req.b  = ALU_W'(take_reg);
                pn_next    = alu_rsp.res[PN_W-1:0];
                state_next = S_U2;
            end
            S_U2: begin
                alu_req.a   = ALU_W'(left_reg);
                alu_req.b   = ALU_W'(take_reg);
                alu_req.sub = 1'b1;
                left_next   = alu_rsp.res[LEFT_W-1:0];
                state_next  = S_U3;
            end
            S_U3: begin
                alu_req.a  = ALU_W'(cur_pages_reg);
                alu_req.b  = ALU_W'(take_reg);
                mem_we     = 1'b1;
                state_next = S_U4;
            end
            S_U4: begin
                alu_req.a  = ALU_W'(total_reg);
                alu_req.b  = ALU_W'(take_reg);
                total_next = alu_rsp.res[TOTAL_W-1:0];
                state_next = S_P_CHK;
            end
            // translate: range check, first extent read issued
            S_X_CHK: begin
                alu_req.a   = ALU_W'(index_reg);
                alu_req.b   = ALU_W'(total_reg);
                alu_req.sub = 1'b1;
                if (!alu_rsp.borrow || (count_reg == '0)) begin
                    st_next    = ST_INDEX;
                    state_next = S_DONE;
                end else begin
                    state_next = S_X_CMP;
                end
            end
            // walk extents, next row read ahead
            S_X_CMP: begin
                rd_cnt      = e_reg + CNT_W'(1);
                alu_req.a   = ALU_W'(index_reg);
                alu_req.b   = ALU_W'(rd_pages);
                alu_req.sub = 1'b1;
                if (alu_rsp.borrow) begin
                    cur_base_next = rd_base;
                    state_next    = S_X_ADDR;
                end else begin
                    index_next = alu_rsp.res[PI_W-1:0];
                    e_next     = e_reg + CNT_W'(1);
                    if ((e_reg + CNT_W'(1)) == count_reg) begin
                        st_next    = ST_INDEX;
                        state_next = S_DONE;
                    end
                end
            end
            S_X_ADDR: begin
                alu_req.a  = ALU_W'(cur_base_reg);
                alu_req.b  = ALU_W'(index_reg);
                oaddr_next = {alu_rsp.res[PA_W-PAGE_SHIFT-1:0], {PAGE_SHIFT{1'b0}}};
                state_next = S_DONE;
            end
            // hand the result to the output register
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{M_PAD_W{1'b0}}, total_reg, count_reg, oaddr_reg, st_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
            max_pa_reg  <= CFG_DATA_W'(1) << PA_W;
            entries_reg <= CNT_W'(64);
            max_ppe_reg <= '1;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_MAX_PHYS_ADDR:  max_pa_reg  <= cfg_wdata;
                    CFG_ENTRIES_IN_USE: entries_reg <= cfg_wdata[CNT_W-1:0];
                    CFG_MAX_PAGES_EXT:  max_ppe_reg <= cfg_wdata[PAGES_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        pn_reg        <= pn_next;
        ofs_reg       <= ofs_next;
        bytes_reg     <= bytes_next;
        index_reg     <= index_next;
        left_reg      <= left_next;
        lim_reg       <= lim_next;
        tmp_reg       <= tmp_next;
        take_reg      <= take_next;
        end_reg       <= end_next;
        cur_base_reg  <= cur_base_next;
        cur_pages_reg <= cur_pages_next;
        cur_idx_reg   <= cur_idx_next;
        e_reg         <= e_next;
        st_reg        <= st_next;
        oaddr_reg     <= oaddr_next;
        m_data_reg    <= m_data_next;
    end

    // a run always places at least one page
    a_take_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_U1) |-> (take_reg != '0))
        else $error("empty run in append");

    // total grows after each applied run
    a_total_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_U4) |=> (total_reg != $past(total_reg)))
        else $error("total did not grow");

    // extent count stays within the table
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("extent count beyond table");

    // results appear only from the done step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result outside done step");

endmodule

// ===== rtl/pelb_alu.sv =====
module pelb_alu (
    input  pelb_pkg::alu_req_t req,
    output pelb_pkg::alu_rsp_t rsp
);
    import pelb_pkg::*;

    logic [ALU_W:0] sum;

    // one adder serves both add and subtract, top bit is carry or borrow
    assign sum = req.sub ? ({1'b0, req.a} - {1'b0, req.b})
                         : ({1'b0, req.a} + {1'b0, req.b});

    assign rsp.res    = sum[ALU_W-1:0];
    assign rsp.borrow = sum[ALU_W];

endmodule

// ===== rtl/pelb_mem.sv =====
module pelb_mem #(
    parameter int DEPTH  = 64,
    parameter int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int BASE_W = 40
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [IDX_W-1:0]             wr_idx,
    input  logic [BASE_W-1:0]            wr_base,
    input  logic [pelb_pkg::PAGES_W-1:0] wr_pages,
    input  logic [IDX_W-1:0]             rd_idx,
    output logic [BASE_W-1:0]            rd_base,
    output logic [pelb_pkg::PAGES_W-1:0] rd_pages
);
    import pelb_pkg::*;

    localparam int ROW_W = BASE_W + PAGES_W;

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rd_row_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= {wr_base, wr_pages};
        end
        rd_row_reg <= mem[rd_idx];
    end

    assign rd_base  = rd_row_reg[ROW_W-1:PAGES_W];
    assign rd_pages = rd_row_reg[PAGES_W-1:0];

endmodule

// ===== tb/pelb_tb_pkg.sv =====
package pelb_tb_pkg;
    import pelb_pkg::*;

    localparam int EXTENT_SLOTS = 64;
    localparam int ADDR_BITS = 52;
    localparam longint unsigned TOTAL_MAX = 64'hFFFF_FFFF;
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [PA_W-1:0]    out_addr;
        logic [CNT_W-1:0]   entry_count;
        logic [TOTAL_W-1:0] total_pages;
    } answer_t;

    // shadow copy of the extent list and the answers it still owes
    class extent_list_tracker;
        logic [CFG_DATA_W-1:0] max_phys_addr;
        logic [CNT_W-1:0]      entries_in_use;
        logic [PAGES_W-1:0]    max_pages_per_extent;
        logic [39:0]           base_page [EXTENT_SLOTS];
        logic [PAGES_W-1:0]    page_count [EXTENT_SLOTS];
        int unsigned           extent_count;
        logic [TOTAL_W-1:0]    page_total;
        answer_t               pending_answers [$];
        int unsigned           mismatches;

        function new();
            max_phys_addr = {1'b1, 52'd0};
            entries_in_use = 7'd64;
            max_pages_per_extent = '1;
            extent_count = 0;
            page_total = '0;
            mismatches = 0;
            foreach (base_page[i]) begin
                base_page[i] = '0;
                page_count[i] = '0;
            end
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_MAX_PHYS_ADDR:  max_phys_addr = value;
                CFG_ENTRIES_IN_USE: entries_in_use = value[CNT_W-1:0];
                CFG_MAX_PAGES_EXT:  max_pages_per_extent = value[PAGES_W-1:0];
                default: ;
            endcase
        endfunction

        // place every page of the byte range, checking address, total, table
        function logic [ST_W-1:0] append_range(logic [PA_W-1:0] addr, logic [BC_W-1:0] bytes);
            longint unsigned cap, left, pn, lim, limit_per, take;
            int unsigned last;
            bit grow;
            cap = (entries_in_use < EXTENT_SLOTS) ? 64'(entries_in_use) : 64'(EXTENT_SLOTS);
            if (cap == 0)
                return ST_NOCAP;
            left = (64'(addr[PAGE_SHIFT-1:0]) + 64'(bytes) + 64'(PAGE_BYTES - 1))
                   >> PAGE_SHIFT;
            pn = 64'(addr) >> PAGE_SHIFT;
            lim = (64'(max_phys_addr) + 64'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
            if (lim > (64'd1 << (ADDR_BITS - PAGE_SHIFT)))
                lim = 64'd1 << (ADDR_BITS - PAGE_SHIFT);
            limit_per = (max_pages_per_extent != 0) ? 64'(max_pages_per_extent) : 64'd1;
            while (left != 0) begin
                if (pn >= lim)
                    return ST_ADDR;
                if (64'(page_total) >= TOTAL_MAX)
                    return ST_OVERFLOW;
                grow = 1'b0;
                if (extent_count != 0) begin
                    last = extent_count - 1;
                    grow = (pn == 64'(base_page[last]) + 64'(page_count[last])) &&
                           (64'(page_count[last]) < limit_per);
                end
                // open a new extent when the page does not continue the last one or it is full
                if (!grow) begin
                    if (extent_count >= cap)
                        return ST_FULL;
                    base_page[extent_count] = pn[39:0];
                    page_count[extent_count] = '0;
                    extent_count++;
                end
                last = extent_count - 1;
                take = left;
                if (lim - pn < take)
                    take = lim - pn;
                if (TOTAL_MAX - 64'(page_total) < take)
                    take = TOTAL_MAX - 64'(page_total);
                if (limit_per - 64'(page_count[last]) < take)
                    take = limit_per - 64'(page_count[last]);
                page_count[last] += take[31:0];
                page_total += take[31:0];
                pn += take;
                left -= take;
            end
            return ST_OK;
        endfunction

        // walk the extents in order to find the page
        function logic [ST_W-1:0] translate(input logic [PI_W-1:0] index,
                                            output logic [PA_W-1:0] addr);
            longint unsigned rest, full;
            addr = '0;
            rest = 64'(index);
            if (rest >= 64'(page_total))
                return ST_INDEX;
            for (int e = 0; e < extent_count; e++) begin
                if (rest < 64'(page_count[e])) begin
                    full = (64'(base_page[e]) + rest) << PAGE_SHIFT;
                    addr = full[PA_W-1:0];
                    return ST_OK;
                end
                rest -= 64'(page_count[e]);
            end
            return ST_INDEX;
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic [PA_W-1:0] addr,
                                   logic [BC_W-1:0] bytes, logic [PI_W-1:0] index);
            answer_t a;
            logic [PA_W-1:0] found;
            a.status = ST_OK;
            found = '0;
            case (func)
                FN_CLEAR: begin
                    extent_count = 0;
                    page_total = '0;
                end
                FN_APPEND: a.status = append_range(addr, bytes);
                FN_XLATE:  a.status = translate(index, found);
                default: ;
            endcase
            a.out_addr = found;
            a.entry_count = CNT_W'(extent_count);
            a.total_pages = page_total;
            pending_answers.push_back(a);
        endfunction

        function void check_answer(logic [M_TDATA_W-1:0] data);
            answer_t got, want;
            got.status = data[ST_W-1:0];
            got.out_addr = data[ST_W +: PA_W];
            got.entry_count = data[ST_W+PA_W +: CNT_W];
            got.total_pages = data[ST_W+PA_W+CNT_W +: TOTAL_W];
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d addr %h count %0d total %0d",
                             got.status, got.out_addr, got.entry_count, got.total_pages);
                return;
            end
            want = pending_answers.pop_front();
            if (got.status != want.status || got.out_addr != want.out_addr ||
                got.entry_count != want.entry_count ||
                got.total_pages != want.total_pages) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected status %0d addr %h count %0d total %0d,",
                             want.status, want.out_addr, want.entry_count, want.total_pages);
                    $display("          got status %0d addr %h count %0d total %0d",
                             got.status, got.out_addr, got.entry_count, got.total_pages);
                end
            end
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction
    endclass

endpackage

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pelb_pkg::*;
    import pelb_tb_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int S_PAD_W = S_TDATA_W - PA_W - BC_W - PI_W;
    localparam logic [CFG_DATA_W-1:0] ADDR_TOP = {1'b1, 52'd0};

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    extent_list_tracker tracker;
    bit calm = 1'b0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    page_extent_list_builder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 aclk = ~aclk;

    // result side: random back-pressure, one long hold-off when asked
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 6);
        end
    end

    // compare each taken result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_answer(m_tdata);
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint unsigned rand64();
        return {$urandom(), $urandom()};
    endfunction

    // offer one request and wait for it to be taken
    task automatic send_request(logic [FUNC_W-1:0] func, logic [PA_W-1:0] addr,
                                logic [BC_W-1:0] bytes, logic [PI_W-1:0] index);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {S_PAD_W'(0), index, bytes, addr};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        tracker.note_request(func, addr, bytes, index);
    endtask

    // drain all outstanding results, block is idle afterwards
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] max_addr, logic [CNT_W-1:0] entries,
                              logic [PAGES_W-1:0] per_extent);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MAX_PHYS_ADDR;
        cfg_wdata <= max_addr;
        @(posedge aclk);
        tracker.write_register(CFG_MAX_PHYS_ADDR, max_addr);
        cfg_index <= CFG_ENTRIES_IN_USE;
        cfg_wdata <= CFG_DATA_W'(entries);
        @(posedge aclk);
        tracker.write_register(CFG_ENTRIES_IN_USE, CFG_DATA_W'(entries));
        cfg_index <= CFG_MAX_PAGES_EXT;
        cfg_wdata <= CFG_DATA_W'(per_extent);
        @(posedge aclk);
        tracker.write_register(CFG_MAX_PAGES_EXT, CFG_DATA_W'(per_extent));
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] max_addr;
        logic [CNT_W-1:0]      entries;
        logic [PAGES_W-1:0]    per_extent;
        logic [PA_W-1:0]       addr;
        logic [BC_W-1:0]       bytes;
        logic [PI_W-1:0]       index;
        logic [TOTAL_W-1:0]    total;
        longint unsigned       lim_pages, cursor;
        int                    roll;

        tracker = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // widest settings: empty lookup, page crossing, top page, func 3
        set_config(ADDR_TOP, 7'd64, 32'hFFFF_FFFF);
        send_request(FN_XLATE, '0, '0, '0);
        send_request(FN_APPEND, '0, '0, '0);
        send_request(FN_APPEND, 52'hFFF, 32'd2, '0);
        send_request(FN_APPEND, 52'h2000, 32'h1000, '0);
        send_request(FN_APPEND, '1, '1, '0);
        send_request(FN_XLATE, '0, '0, 32'd2);
        send_request(FN_XLATE, '0, '0, 32'd3);
        send_request(FN_XLATE, '0, '0, 32'd4);
        send_request(FN_XLATE, '0, '0, '1);
        send_request(FN_UNUSED, '1, '1, '1);
        send_request(FN_CLEAR, '1, '1, '1);

        // lowest address limit, single entry, zero extent limit
        settle();
        set_config(CFG_DATA_W'(PAGE_BYTES), 7'd1, 32'd0);
        send_request(FN_APPEND, '0, 32'd4096, '0);
        send_request(FN_APPEND, 52'h1000, 32'd1, '0);
        send_request(FN_APPEND, '0, 32'h3000, '0);

        // small extent limit splits one range into several extents
        settle();
        set_config(ADDR_TOP, 7'd64, 32'd2);
        send_request(FN_CLEAR, '0, '0, '0);
        send_request(FN_APPEND, 52'h10000, 32'h5000, '0);
        send_request(FN_XLATE, '0, '0, 32'd4);

        // capacity lowered under the extent count: growth only
        settle();
        set_config(ADDR_TOP, 7'd2, 32'd2);
        send_request(FN_APPEND, 52'h15000, 32'h1000, '0);
        send_request(FN_APPEND, 52'h16000, 32'h1000, '0);

        // extent limit lowered under the last extent's size
        settle();
        set_config(ADDR_TOP, 7'd64, 32'd1);
        send_request(FN_APPEND, 52'h16000, 32'h1000, '0);

        // no capacity at all
        settle();
        set_config(ADDR_TOP, 7'd0, 32'hFFFF_FFFF);
        send_request(FN_APPEND, '0, '0, '0);
        send_request(FN_XLATE, '0, '0, '0);

        // contiguous full-size ranges growing one large extent
        settle();
        set_config(ADDR_TOP, 7'd64, 32'hFFFF_FFFF);
        send_request(FN_CLEAR, '0, '0, '0);
        for (int k = 0; k < 64; k++)
            send_request(FN_APPEND, PA_W'(64'(k) << 32), 32'hFFFF_FFFF, '0);
        for (int k = 0; k < 24; k++)
            send_request(FN_XLATE, PA_W'(rand64()), $urandom(), $urandom());
        send_request(FN_APPEND, '1, 32'd1, '0);

        // random phases, each with its own settings
        cursor = 0;
        for (int phase = 0; phase < 8; phase++) begin
            settle();
            calm = (phase == 3);
            case ($urandom_range(3))
                0: max_addr = ADDR_TOP;
                1: max_addr = CFG_DATA_W'(PAGE_BYTES);
                default: begin
                    max_addr = CFG_DATA_W'(rand64() >> $urandom_range(40, 12));
                    if (max_addr < PAGE_BYTES)
                        max_addr = CFG_DATA_W'(PAGE_BYTES);
                end
            endcase
            case ($urandom_range(7))
                0: entries = 7'd0;
                1: entries = 7'd1;
                2, 3: entries = 7'd64;
                default: entries = CNT_W'($urandom_range(64, 1));
            endcase
            case ($urandom_range(7))
                0: per_extent = '1;
                1: per_extent = 32'd1;
                2: per_extent = 32'd0;
                3: per_extent = $urandom();
                default: per_extent = PAGES_W'($urandom_range(16, 1));
            endcase
            set_config(max_addr, entries, per_extent);
            lim_pages = (64'(max_addr) + 64'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
            if (lim_pages > (64'd1 << (ADDR_BITS - PAGE_SHIFT)))
                lim_pages = 64'd1 << (ADDR_BITS - PAGE_SHIFT);
            if (phase == 5)
                hold_token++;
            if ($urandom_range(1) == 0)
                send_request(FN_CLEAR, PA_W'(rand64()), $urandom(), $urandom());

            for (int n = 0; n < 145; n++) begin
                roll = $urandom_range(99);
                if (roll < 50) begin
                    // append, mostly continuing the previous range
                    if ($urandom_range(3) == 0)
                        cursor = rand64() % lim_pages;
                    if ($urandom_range(49) == 0)
                        bytes = $urandom();
                    else
                        bytes = BC_W'($urandom_range(6 * PAGE_BYTES, 0));
                    addr = PA_W'((cursor << PAGE_SHIFT) |
                                 64'($urandom_range(PAGE_BYTES - 1, 0)));
                    send_request(FN_APPEND, addr, bytes, $urandom());
                    cursor = (64'(addr) + 64'(bytes) + 64'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
                end else if (roll < 80) begin
                    // lookup, mostly inside the described pages
                    total = tracker.page_total;
                    if (total != 0 && $urandom_range(9) != 0)
                        index = $urandom_range(total - 1, 0);
                    else
                        index = total + PI_W'($urandom_range(3, 0));
                    send_request(FN_XLATE, PA_W'(rand64()), $urandom(), index);
                end else if (roll < 84) begin
                    send_request(FN_CLEAR, PA_W'(rand64()), $urandom(), $urandom());
                end else begin
                    send_request(FUNC_W'($urandom_range(3)), PA_W'(rand64()), $urandom(),
                                 $urandom());
                end
            end
        end

        settle();
        repeat (40) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
